// ----- src/lfu_pkg.sv -----
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by every module of the block.
package lfu_pkg;

  // Parameter defaults
  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int PAGE_IN_W   = 16;
  localparam int FRAME_OUT_W = 3;
  localparam int CTR_W       = 32;
  localparam int FIU_W       = 4;
  localparam int OUT_FIELD_W = 1 + FRAME_OUT_W + 1 + PAGE_IN_W + 2 * CTR_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = 2'd0;
  localparam logic [FIU_W-1:0]  FIU_RESET          = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } lfu_state_t;

  typedef struct packed {
    logic load;    // capture the incoming page number
    logic search;  // register the lookup and victim decision
    logic update;  // write the frame table and load the result register
  } lfu_cmd_t;

endpackage

// ----- src/lfu_ctrl.sv -----
// Controller state machine for the LFU page replacement block.
// Depends on lfu_pkg for the state encoding and command struct.
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output lfu_cmd_t cmd
);

  lfu_state_t state, state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) || ((state == S_UPDATE) && out_free);
  assign accept   = s_tvalid && s_tready;

  assign cmd.load   = accept;
  assign cmd.search = (state == S_SEARCH);
  assign cmd.update = (state == S_UPDATE) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) state_next = accept ? S_SEARCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- src/lfu_datapath.sv -----
// Frame table, lookup, victim selection and result register.
// Depends on lfu_pkg; driven by commands from lfu_ctrl.
module lfu_datapath import lfu_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfu_cmd_t               cmd,
  input  logic [FIU_W-1:0]       frames_in_use,
  input  logic [PAGE_IN_W-1:0]   in_page,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int ACT_W  = ($clog2(MAX_FRAMES + 1) > FIU_W) ? $clog2(MAX_FRAMES + 1) : FIU_W;
  localparam int LEAVES = 1 << IW;
  localparam int KW     = COUNT_BITS + IW;
  localparam logic [ACT_W-1:0] ACT_MAX = ACT_W'(MAX_FRAMES);

  // Frame table
  logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES];
  logic [COUNT_BITS-1:0] use_count  [MAX_FRAMES];
  logic [IW-1:0]         rank       [MAX_FRAMES];  // position in recency order
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [CTR_W-1:0]      faults_so_far, hits_so_far;
  logic [CTR_W-1:0]      faults_next, hits_next;

  logic [PAGE_BITS-1:0] cur_page;

  // Decision registers
  logic                 d_hit, d_evict;
  logic [IW-1:0]        d_frame;
  logic [PAGE_BITS-1:0] d_old_page;

  // Result register
  logic                   o_hit, o_evicted;
  logic [FRAME_OUT_W-1:0] o_frame;
  logic [PAGE_IN_W-1:0]   o_evicted_page;
  logic [CTR_W-1:0]       o_faults, o_hits;

  logic [ACT_W-1:0]      act;
  logic [MAX_FRAMES-1:0] active;
  logic                  any_hit, any_empty;
  logic [IW-1:0]         hit_idx, empty_idx, victim_idx, sel_frame;
  logic [IW-1:0]         r0;

  logic [KW-1:0] tk   [2*LEAVES];
  logic [IW-1:0] tidx [2*LEAVES];
  logic          tok  [2*LEAVES];

  always_comb begin
    if (frames_in_use == '0) act = ACT_W'(1);
    else if (ACT_W'(frames_in_use) > ACT_MAX) act = ACT_MAX;
    else act = ACT_W'(frames_in_use);
    for (int f = 0; f < MAX_FRAMES; f++) begin
      active[f] = ACT_W'(f) < act;
    end
  end

  // Lowest matching frame and lowest empty frame
  always_comb begin
    any_hit   = 1'b0;
    any_empty = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    for (int f = MAX_FRAMES - 1; f >= 0; f--) begin
      if (active[f] && frame_valid[f] && (frame_page[f] == cur_page)) begin
        any_hit = 1'b1;
        hit_idx = IW'(f);
      end
      if (active[f] && !frame_valid[f]) begin
        any_empty = 1'b1;
        empty_idx = IW'(f);
      end
    end
  end

  // Victim: smallest {use count, recency rank} over active frames, by a binary tree
  always_comb begin
    for (int n = 0; n < 2 * LEAVES; n++) begin
      tk[n]   = '0;
      tidx[n] = '0;
      tok[n]  = 1'b0;
    end
    for (int f = 0; f < MAX_FRAMES; f++) begin
      tk[LEAVES+f]   = {use_count[f], rank[f]};
      tidx[LEAVES+f] = IW'(f);
      tok[LEAVES+f]  = active[f];
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (tok[2*n] && (!tok[2*n+1] || (tk[2*n] < tk[2*n+1]))) begin
        tk[n]   = tk[2*n];
        tidx[n] = tidx[2*n];
      end else begin
        tk[n]   = tk[2*n+1];
        tidx[n] = tidx[2*n+1];
      end
      tok[n] = tok[2*n] || tok[2*n+1];
    end
    victim_idx = tidx[1];
  end

  assign sel_frame = any_hit ? hit_idx : (any_empty ? empty_idx : victim_idx);
  assign r0        = rank[d_frame];

  always_comb begin
    faults_next = faults_so_far;
    hits_next   = hits_so_far;
    if (d_hit) begin
      if (hits_so_far != '1) hits_next = hits_so_far + 1'b1;
    end else begin
      if (faults_so_far != '1) faults_next = faults_so_far + 1'b1;
    end
  end

  // Control-like state: valid marks, recency ranks, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      faults_so_far <= '0;
      hits_so_far   <= '0;
      for (int f = 0; f < MAX_FRAMES; f++) rank[f] <= IW'(f);
    end else if (cmd.update) begin
      faults_so_far <= faults_next;
      hits_so_far   <= hits_next;
      if (!d_hit) frame_valid[d_frame] <= 1'b1;
      // move the touched frame to the most recent end
      for (int f = 0; f < MAX_FRAMES; f++) begin
        if (rank[f] > r0) rank[f] <= rank[f] - 1'b1;
      end
      rank[d_frame] <= IW'(MAX_FRAMES - 1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) cur_page <= PAGE_BITS'(in_page);
    if (cmd.search) begin
      d_hit      <= any_hit;
      d_evict    <= !any_hit && !any_empty;
      d_frame    <= sel_frame;
      d_old_page <= (!any_hit && !any_empty) ? frame_page[victim_idx] : '0;
    end
    if (cmd.update) begin
      if (d_hit) begin
        if (use_count[d_frame] != '1) use_count[d_frame] <= use_count[d_frame] + 1'b1;
      end else begin
        frame_page[d_frame] <= cur_page;
        use_count[d_frame]  <= COUNT_BITS'(1);
      end
      o_hit          <= d_hit;
      o_frame        <= FRAME_OUT_W'(d_frame);
      o_evicted      <= d_evict;
      o_evicted_page <= PAGE_IN_W'(d_old_page);
      o_faults       <= faults_next;
      o_hits         <= hits_next;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, o_hits, o_faults, o_evicted_page,
                    o_evicted, o_frame, o_hit};

endmodule

// ----- src/lfu_page_replacement.sv -----
// Flow: an accepted input is captured, passes the search state, then the update state,
//   which registers the result and waits while an offered result is not yet taken. The
//   search stage (parallel tag compare plus a tree minimum over use count and recency) and
//   the table update stage are separate states; the next input is taken in update.
// Reset (rst, synchronous): clears valid marks, counters and the result valid, sets
//   recency to frame index order and frames_in_use to 8. No clearing pass.
module lfu_page_replacement import lfu_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PAGE_IN_W-1:0]   s_tdata,   // [15:0] page_number
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] hit, [3:1] frame_index, [4] evicted,
                                            // [20:5] evicted_page, [52:21] fault_count,
                                            // [84:53] hit_count, [87:85] zero
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [FIU_W-1:0] frames_in_use;
  lfu_cmd_t         cmd;

  // Configuration register: the user must write it only while the block is idle; the block does not enforce this.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FIU_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_FRAMES_IN_USE)) begin
      frames_in_use <= pwdata[FIU_W-1:0];
    end
  end

  // Reads of addresses outside the map return zero.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_FRAMES_IN_USE) prdata = APB_DW'(frames_in_use);
  end

  // Sequencer: idle / search / update; owns both handshakes.
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Frame table, decision logic and the result register.
  lfu_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .frames_in_use (frames_in_use),
    .in_page       (s_tdata),
    .m_tdata       (m_tdata)
  );

endmodule

// ----- src/lfu_checker.sv -----
// Port-level checks for lfu_page_replacement, attached by bind.
// Depends on lfu_pkg for port widths.
module lfu_checker import lfu_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Search cycle follows every input transfer: no transfer in the next cycle.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during search");

  // Every input transfer yields a valid result.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##3 m_tvalid)
    else $error("result missing after input transfer");

  // A hit never evicts; nothing evicted means a zero evicted page.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[4]) && (m_tdata[4] || (m_tdata[20:5] == '0)))
    else $error("inconsistent hit/evicted fields");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- verif/lfu_page_replacement_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lfu_page_replacement: streams page references in, predicts
// every lookup result with an LFU model (LRU tie-break) of its own and checks the result
// stream. Depends on lfu_pkg and the block's RTL; reads no files.
module lfu_page_replacement_test;
  import lfu_pkg::*;

  localparam int NFRAMES     = MAX_FRAMES_DEF;
  localparam int POOL_SIZE   = 12;
  localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int REPORT_MAX  = 10;

  // One result transfer, packed so that the last field sits in the lowest bits of tdata.
  typedef struct packed {
    logic [CTR_W-1:0]       hit_count;
    logic [CTR_W-1:0]       fault_count;
    logic [PAGE_IN_W-1:0]   evicted_page;
    logic                   evicted;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   hit;
  } access_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PAGE_IN_W-1:0]   s_tdata;   // [15:0] page_number
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] hit, [3:1] frame_index, [4] evicted,
                                     // [20:5] evicted_page, [52:21] fault_count,
                                     // [84:53] hit_count, [87:85] zero
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  lfu_page_replacement i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // Shadow of the block's frame table, recency order, counters and register.
  logic [PAGE_IN_W-1:0]   shadow_page  [NFRAMES];
  logic                   shadow_valid [NFRAMES];
  logic [15:0]            shadow_uses  [NFRAMES];
  logic [FRAME_OUT_W-1:0] recency      [NFRAMES];  // [0] is least recently used
  logic [CTR_W-1:0]       faults_seen;
  logic [CTR_W-1:0]       hits_seen;
  logic [FIU_W-1:0]       frames_reg;

  access_result_t       pending_results[$];
  logic [PAGE_IN_W-1:0] page_pool[POOL_SIZE];
  int                   fail_count = 0;
  bit                   src_idle_on = 1'b1;
  bit                   sink_idle_on = 1'b1;
  int                   sink_hold = 0;
  int                   quiet_cycles = 0;

  function automatic void clear_shadow();
    int i;
    for (i = 0; i < NFRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_uses[i]  = '0;
      recency[i]      = FRAME_OUT_W'(i);
    end
    faults_seen = '0;
    hits_seen   = '0;
    frames_reg  = FIU_RESET;
  endfunction

  // Work out the lookup result for one page reference and advance the shadow state.
  function automatic access_result_t predict_access(input logic [PAGE_IN_W-1:0] page);
    access_result_t       r;
    int                   i, q, act, frame, f;
    bit                   found, chosen;
    logic [15:0]          best;
    r      = '0;
    found  = 1'b0;
    chosen = 1'b0;
    frame  = 0;
    best   = '0;
    q      = 0;
    // An out-of-range register value is clamped to 1..NFRAMES
    act = (frames_reg == 0) ? 1 : ((frames_reg > NFRAMES) ? NFRAMES : int'(frames_reg));

    // Lowest active frame holding the page wins, even if it is resident twice
    for (i = 0; i < act; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == page) begin
        found = 1'b1;
        frame = i;
      end
    end

    if (found) begin
      if (shadow_uses[frame] != 16'hFFFF) shadow_uses[frame]++;
      if (hits_seen != '1) hits_seen++;
    end else begin
      // Fill the lowest empty active frame first
      for (i = 0; i < act; i++) begin
        if (!chosen && !shadow_valid[i]) begin
          chosen = 1'b1;
          frame  = i;
        end
      end
      if (!chosen) begin
        // Smallest use count; walking from the LRU end keeps the oldest on a tie
        for (i = 0; i < NFRAMES; i++) begin
          f = int'(recency[i]);
          if (f < act && (!chosen || shadow_uses[f] < best)) begin
            best   = shadow_uses[f];
            frame  = f;
            chosen = 1'b1;
          end
        end
        r.evicted      = 1'b1;
        r.evicted_page = shadow_page[frame];
      end
      shadow_page[frame]  = page;
      shadow_valid[frame] = 1'b1;
      shadow_uses[frame]  = 16'd1;
      if (faults_seen != '1) faults_seen++;
    end

    // Move the touched frame to the most recent end
    for (i = NFRAMES - 1; i >= 0; i--) begin
      if (int'(recency[i]) == frame) q = i;
    end
    for (i = q; i < NFRAMES - 1; i++) recency[i] = recency[i + 1];
    recency[NFRAMES - 1] = FRAME_OUT_W'(frame);

    r.hit         = found;
    r.frame_index = FRAME_OUT_W'(frame);
    r.fault_count = faults_seen;
    r.hit_count   = hits_seen;
    return r;
  endfunction

  function automatic string show(input access_result_t r);
    return $sformatf("hit=%0d frame=%0d evicted=%0d evicted_page=%h faults=%0d hits=%0d",
                     r.hit, r.frame_index, r.evicted, r.evicted_page, r.fault_count,
                     r.hit_count);
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PAGE_IN_W-1:0] pick_page();
    if ($urandom_range(0, 99) < 15) return PAGE_IN_W'($urandom());
    // Skew toward the low pool entries so that use counts spread apart
    return page_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
  endfunction

  function automatic void refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 1) == 1) page_pool[i] = PAGE_IN_W'($urandom());
    end
  endfunction

  // Offer one page reference and hold it until the transfer. Valid stays high after the
  // transfer; the next call or drain_results() decides at the next falling edge whether
  // it drops, so valid never gets two updates in one time step.
  task automatic send_page(input logic [PAGE_IN_W-1:0] page);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= PAGE_IN_W'($urandom());
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= page;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_access(page));
  endtask

  // Drop valid, then hold until every expected result has come.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_check_frames();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_FRAMES_IN_USE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[FIU_W-1:0] !== frames_reg)
      report_failure($sformatf("frames_in_use read: expected %0d, got %0d",
                               frames_reg, prdata[FIU_W-1:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reconfigure only with the block idle, then read the register back.
  task automatic set_frames(input logic [APB_DW-1:0] value);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FRAMES_IN_USE;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    frames_reg = value[FIU_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom();
    read_check_frames();
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  task automatic test_after_reset();
    read_check_frames();
  endtask

  // Fill all eight frames with extreme page numbers, build up a few use counts, then force
  // two evictions, each where several frames tie at the smallest count, 1; then use one frame.
  task automatic test_fill_and_evict();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h8000);
    send_page(16'h0001);
    send_page(16'h7FFF);
    send_page(16'hFFFE);
    send_page(16'hFFFF);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'h4321);
    send_page(16'h1234);
    // Single frame: every miss replaces frame 0
    set_frames(32'd1);
    send_page(16'h0000);
    send_page(16'hBEEF);
    send_page(16'hBEEF);
    send_page(16'h0000);
  endtask

  // Out-of-range register values clamp: 0 acts as 1, above 8 acts as 8.
  task automatic test_register_limits();
    int k;
    set_frames(32'd0);
    for (k = 0; k < 4; k++) send_page(pick_page());
    set_frames(32'd15);
    for (k = 0; k < 6; k++) send_page(pick_page());
    set_frames(32'd9);
    for (k = 0; k < 6; k++) send_page(pick_page());
  endtask

  // Shrink the active set so that a page in a hidden frame is loaded again into an active
  // one, then grow back: the hidden copy survives and the lowest copy wins the lookup.
  task automatic test_hidden_frames();
    logic [PAGE_IN_W-1:0] hidden_page, last_page;
    int i;
    set_frames(32'd8);
    for (i = 0; i < NFRAMES; i++) send_page(PAGE_IN_W'($urandom()));
    drain_results();
    hidden_page = shadow_page[5];
    last_page   = shadow_page[7];
    set_frames(32'd3);
    send_page(hidden_page);
    send_page(pick_page());
    send_page(hidden_page);
    set_frames(32'd8);
    send_page(hidden_page);
    send_page(last_page);
  endtask

  // Hit one page many times back to back with no idling; the next miss must replace its
  // cold neighbor, not the hot page.
  task automatic test_hot_page();
    logic [PAGE_IN_W-1:0] hot_page, cold_page;
    int k;
    hot_page  = PAGE_IN_W'($urandom());
    cold_page = hot_page ^ 16'h00FF;
    set_frames(32'd2);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_page(hot_page);
    send_page(cold_page);
    for (k = 0; k < 40; k++) send_page(hot_page);
    send_page(~hot_page);
    send_page(hot_page);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Random phases over several register settings, extremes included. Each phase idles on
  // both sides, one side only, or none; one phase pauses until it runs dry.
  task automatic test_random_mix();
    logic [FIU_W-1:0] setting[8] = '{4'd8, 4'd1, 4'd5, 4'd0, 4'd15, 4'd3, 4'd12, 4'd8};
    int phase, k;
    for (phase = 0; phase < 8; phase++) begin
      set_frames(($urandom() & 32'hFFFF_FFF0) | APB_DW'(setting[phase]));
      refresh_pool();
      src_idle_on  = (phase % 4) != 1 && (phase % 4) != 3;
      sink_idle_on = (phase % 4) != 1 && (phase % 4) != 2;
      for (k = 0; k < 75; k++) begin
        if (phase == 2 && k == 37) drain_results();
        send_page(pick_page());
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Result sink: random backpressure, changed at the falling edge
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    int g;
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_on) begin
      g = pick_gap();
      sink_hold = (g > 0) ? g - 1 : 0;
      m_tready <= (g == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest prediction, field by field.
  always @(posedge clk) begin
    access_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = access_result_t'(m_tdata[OUT_FIELD_W-1:0]);
      if (pending_results.size() == 0) begin
        report_failure({"result with none expected: ", show(got)});
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
            got.evicted !== want.evicted || got.evicted_page !== want.evicted_page ||
            got.fault_count !== want.fault_count || got.hit_count !== want.hit_count ||
            m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
          report_failure({"mismatch\n  expected ", show(want), "\n  actual   ", show(got),
                          $sformatf(" pad=%b", m_tdata[OUT_TDATA_W-1:OUT_FIELD_W])});
      end
    end
  end

  // Watchdog: any transfer on any port resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lfu_page_replacement regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    clear_shadow();
    refresh_pool();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_fill_and_evict();
    test_register_limits();
    test_hidden_frames();
    test_hot_page();
    test_random_mix();

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("lfu_page_replacement regression: pass");
    end else begin
      $display("lfu_page_replacement regression: fail");
    end
    $finish;
  end

endmodule
